@@ sv/button_pattern_record_playback_defines.svh @@
// ----------------------------------------------------------------------------
// Button pattern record and playback: assertion macros
// Concurrent assertion shorthands clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_PATTERN_RECORD_PLAYBACK_DEFINES_SVH
`define BUTTON_PATTERN_RECORD_PLAYBACK_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define BPRP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Property whose consequent must hold in the cycle after the trigger.
`define BPRP_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/bprp_pkg.sv @@
// ----------------------------------------------------------------------------
// Button pattern record and playback: shared package
// Phase codes, configuration register layout and status types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bprp_pkg;

  // Slot index width; the index always wraps within this range.
  localparam int unsigned IDX_BITS = 6;

  // Configuration register layout.
  localparam int unsigned CFG_IDX_BITS  = 1;
  localparam int unsigned CFG_DATA_BITS = 16;
  localparam int unsigned LIMIT_BITS    = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_IDLE_TICK_LIMIT = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SLOT_LIMIT      = 1'd1;

  localparam logic [LIMIT_BITS-1:0] IDLE_TICK_LIMIT_RST = 16'd300;
  localparam logic [IDX_BITS-1:0]   SLOT_LIMIT_RST      = 6'd35;

  // Operating phase; the spare code behaves as idle without starting a take.
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_RECORD = 2'd1,
    PH_PLAY   = 2'd2
  } phase_e;

  // Configuration register contents.
  typedef struct packed {
    logic [LIMIT_BITS-1:0] idle_tick_limit;
    logic [IDX_BITS-1:0]   slot_limit;
  } cfg_t;

  // LED drive and phase after one tick.
  typedef struct packed {
    logic   red;
    logic   green;
    phase_e phase;
  } tick_out_t;

endpackage

@@ sv/bprp_run_mem.sv @@
// ----------------------------------------------------------------------------
// Button pattern record and playback: run-length slot memory
// One write port and two registered read ports, with write-to-read bypass
// and per-entry valid bits so that unwritten slots read as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bprp_run_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [CW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [CW-1:0] rdata_a_o,
  output logic [CW-1:0] rdata_b_o
);

  logic [CW-1:0]    mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [CW-1:0]    rdata_a_q;
  logic [CW-1:0]    rdata_b_q;

  // Storage array write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Valid bits are cleared by reset, so the whole store reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  // Registered reads; a write to the same slot in this cycle is forwarded.
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_a_i)) begin
      rdata_a_q <= wdata_i;
    end else if (valid_q[raddr_a_i]) begin
      rdata_a_q <= mem_q[raddr_a_i];
    end else begin
      rdata_a_q <= '0;
    end
    if (we_i && (waddr_i == raddr_b_i)) begin
      rdata_b_q <= wdata_i;
    end else if (valid_q[raddr_b_i]) begin
      rdata_b_q <= mem_q[raddr_b_i];
    end else begin
      rdata_b_q <= '0;
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ sv/bprp_tick_core.sv @@
// ----------------------------------------------------------------------------
// Button pattern record and playback: tick engine
// Holds the phase, slot index and LED state, and performs the per-tick
// read-modify-write of the current or the following slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bprp_tick_core #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tick_i,
  input  logic                button_pressed_i,
  input  bprp_pkg::cfg_t      cfg_i,
  input  logic [CW-1:0]       rdata_a_i,
  input  logic [CW-1:0]       rdata_b_i,
  output logic                we_o,
  output logic [AW-1:0]       waddr_o,
  output logic [CW-1:0]       wdata_o,
  output logic [AW-1:0]       raddr_a_o,
  output logic [AW-1:0]       raddr_b_o,
  output bprp_pkg::tick_out_t status_o
);

  import bprp_pkg::*;

  localparam int unsigned     LW       = (CW > LIMIT_BITS) ? CW : LIMIT_BITS;
  localparam logic [IDX_BITS:0] DEPTH_W = (IDX_BITS + 1)'(DEPTH);

  phase_e              phase_q, phase_d;
  logic [IDX_BITS-1:0] slot_q, slot_d;
  logic                prev_q, prev_d;
  logic                lit_q, lit_d;
  logic                red_q, red_d;
  logic                green_q, green_d;

  // Slot index to memory address; only matters when the memory has fewer
  // entries than the index range, and then takes a few subtract steps.
  function automatic logic [AW-1:0] slot_addr(input logic [IDX_BITS-1:0] idx);
    logic [IDX_BITS:0] v;
    v = {1'b0, idx};
    for (int k = 0; k < 8; k++) begin
      if (v >= DEPTH_W) begin
        v = v - DEPTH_W;
      end
    end
    return v[AW-1:0];
  endfunction

  // Saturating increment of a run count.
  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] x);
    return (x == '1) ? x : x + CW'(1);
  endfunction

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PLAY;
      slot_q  <= '0;
      prev_q  <= 1'b0;
      lit_q   <= 1'b1;
      red_q   <= 1'b0;
      green_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      slot_q  <= slot_d;
      prev_q  <= prev_d;
      lit_q   <= lit_d;
      red_q   <= red_d;
      green_q <= green_d;
    end
  end

  // Next state and memory access for one tick.
  always_comb begin
    logic [IDX_BITS-1:0] slot_inc;
    logic [IDX_BITS-1:0] slot_nxt;
    logic [CW-1:0]       run;
    slot_inc = slot_q + IDX_BITS'(1);
    phase_d  = phase_q;
    slot_d   = slot_q;
    prev_d   = prev_q;
    lit_d    = lit_q;
    red_d    = red_q;
    green_d  = green_q;
    we_o     = 1'b0;
    waddr_o  = slot_addr(slot_q);
    wdata_o  = rdata_a_i;
    run      = rdata_a_i;
    if (tick_i) begin
      unique case (phase_q)
        PH_RECORD: begin
          red_d   = 1'b1;
          green_d = button_pressed_i;
          // A level change opens the next slot; otherwise the run grows.
          if (button_pressed_i != prev_q) begin
            prev_d  = button_pressed_i;
            slot_d  = slot_inc;
            waddr_o = slot_addr(slot_inc);
            run     = sat_inc(rdata_b_i);
          end else begin
            run     = sat_inc(rdata_a_i);
          end
          we_o    = 1'b1;
          wdata_o = run;
          // A long enough release ends the take.
          if (!button_pressed_i && (LW'(run) >= LW'(cfg_i.idle_tick_limit))) begin
            red_d   = 1'b0;
            green_d = 1'b0;
            phase_d = PH_PLAY;
            slot_d  = '0;
          end
        end
        PH_PLAY: begin
          // An exhausted slot moves on and flips between press and gap.
          if (rdata_a_i == '0) begin
            slot_d = slot_inc;
            lit_d  = !lit_q;
          end else begin
            red_d   = 1'b0;
            green_d = lit_q;
            we_o    = 1'b1;
            wdata_o = rdata_a_i - CW'(1);
          end
        end
        PH_IDLE: begin
          // A press starts a new take with a run of one in slot zero.
          if (button_pressed_i) begin
            phase_d = PH_RECORD;
            prev_d  = 1'b1;
            slot_d  = '0;
            we_o    = 1'b1;
            waddr_o = slot_addr('0);
            wdata_o = CW'(1);
          end
        end
        default: begin
        end
      endcase
      // Slot limit reached: record goes to playback, playback goes idle.
      if (slot_d >= cfg_i.slot_limit) begin
        if (phase_d == PH_RECORD) begin
          phase_d = PH_PLAY;
          slot_d  = '0;
        end else if (phase_d == PH_PLAY) begin
          phase_d = PH_IDLE;
          red_d   = 1'b0;
          green_d = 1'b0;
          lit_d   = 1'b1;
        end
      end
    end
    // Fetch the slot of the next tick and the one after it.
    slot_nxt  = slot_d + IDX_BITS'(1);
    raddr_a_o = slot_addr(slot_d);
    raddr_b_o = slot_addr(slot_nxt);
  end

  assign status_o.red   = red_d;
  assign status_o.green = green_d;
  assign status_o.phase = phase_d;

endmodule

@@ sv/button_pattern_record_playback.sv @@
// ----------------------------------------------------------------------------
// Button pattern record and playback: top level
// Timer-tick driven recorder that run-length codes button presses into a
// slot memory and plays them back on the LEDs.
// ----------------------------------------------------------------------------
// The block takes one tick per clock cycle while its output is not stalled,
// and each tick's result appears in the output register in the cycle after
// the transfer. The rate is set by the slot memory: every tick does at most
// one read-modify-write of a single slot, and the two read ports prefetch
// the current and the following slot so the next tick finds its data ready.
// The memory is cleared by reset in the same cycle through per-slot valid
// bits; input transfers wait until the start register is set after reset.
`timescale 1ns / 1ps

module button_pattern_record_playback #(
  parameter int unsigned SLOTS      = 64,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              button_pressed_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              red_led_o,
  output logic                              green_led_o,
  output logic [1:0]                        phase_o,
  input  logic                              cfg_we_i,
  input  logic [bprp_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [bprp_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i
);

  import bprp_pkg::*;

  // Only the slots the index can reach are stored.
  localparam int unsigned DEPTH = (SLOTS < (1 << IDX_BITS)) ? SLOTS : (1 << IDX_BITS);
  localparam int unsigned AW    = $clog2(DEPTH);

  cfg_t                cfg_q;
  logic                start_q;
  logic                out_valid_q;
  tick_out_t           out_q;
  tick_out_t           status;
  logic                tick;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [AW-1:0]       mem_raddr_a;
  logic [AW-1:0]       mem_raddr_b;
  logic [COUNT_BITS-1:0] mem_rdata_a;
  logic [COUNT_BITS-1:0] mem_rdata_b;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_tick_limit <= IDLE_TICK_LIMIT_RST;
      cfg_q.slot_limit      <= SLOT_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IDLE_TICK_LIMIT: cfg_q.idle_tick_limit <= cfg_wdata_i[LIMIT_BITS-1:0];
        CFG_SLOT_LIMIT:      cfg_q.slot_limit      <= cfg_wdata_i[IDX_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Hold off input after reset until the start register is set, so the read registers settle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b0;
    end else begin
      start_q <= 1'b1;
    end
  end

  // Once started, a new tick is taken whenever the output register is free or draining.
  assign in_ready_o = start_q && (!out_valid_q || out_ready_i);
  assign tick       = in_valid_i && in_ready_o;

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tick) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (tick) begin
      out_q <= status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_led_o   = out_q.red;
  assign green_led_o = out_q.green;
  assign phase_o     = out_q.phase;

  bprp_tick_core #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (COUNT_BITS)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tick_i           (tick),
    .button_pressed_i (button_pressed_i),
    .cfg_i            (cfg_q),
    .rdata_a_i        (mem_rdata_a),
    .rdata_b_i        (mem_rdata_b),
    .we_o             (mem_we),
    .waddr_o          (mem_waddr),
    .wdata_o          (mem_wdata),
    .raddr_a_o        (mem_raddr_a),
    .raddr_b_o        (mem_raddr_b),
    .status_o         (status)
  );

  bprp_run_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (COUNT_BITS)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

endmodule

@@ sv/bprp_checker.sv @@
// ----------------------------------------------------------------------------
// Button pattern record and playback: port checker
// Concurrent checks on the top-level ports, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "button_pattern_record_playback_defines.svh"

module bprp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       red_led_o,
  input logic       green_led_o,
  input logic [1:0] phase_o
);

  import bprp_pkg::*;

  // A stalled result keeps its valid and its payload.
  `BPRP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(red_led_o) && $stable(green_led_o) && $stable(phase_o), "stalled result changed")

  // Every accepted tick shows a result in the next cycle.
  `BPRP_ASSERT_NEXT(a_tick_result, in_valid_i && in_ready_o, out_valid_o, "accepted tick gave no result")

  // While a result is stuck, no further tick may be taken.
  `BPRP_ASSERT(a_stall_blocks, out_valid_o && !out_ready_i |-> !in_ready_o, "tick taken over a stalled result")

  // Idle phase always shows both LEDs dark.
  `BPRP_ASSERT(a_idle_dark, out_valid_o && (phase_o == PH_IDLE) |-> !red_led_o && !green_led_o, "LED lit in idle")

endmodule

bind button_pattern_record_playback bprp_checker u_bprp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .red_led_o   (red_led_o),
  .green_led_o (green_led_o),
  .phase_o     (phase_o)
);

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// Button pattern record and playback: testbench
// Sends timer ticks with a button level over the input channel. A tick
// predictor tracks phase, slot memory and LED state, and every output
// transfer is checked against the oldest predicted LED and phase result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import bprp_pkg::*;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic                     button_pressed_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic                     red_led_o;
  logic                     green_led_o;
  logic [1:0]               phase_o;
  logic                     cfg_we_i;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i;
  logic [CFG_DATA_BITS-1:0] cfg_wdata_i;

  // Predicted recorder state and its copy of the limit registers.
  phase_e               exp_phase;
  logic [IDX_BITS-1:0]  exp_slot;
  logic                 exp_prev_pressed;
  logic                 exp_play_lit;
  logic [15:0]          exp_runs [64];
  logic                 exp_red;
  logic                 exp_green;
  logic [15:0]          exp_idle_limit;
  logic [IDX_BITS-1:0]  exp_slot_limit;

  // LED and phase results still owed by the block, oldest first.
  tick_out_t            pending_leds [$];

  int unsigned          ticks_sent;
  int unsigned          errors;
  logic                 steady;

  button_pattern_record_playback uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .button_pressed_i (button_pressed_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .red_led_o        (red_led_o),
    .green_led_o      (green_led_o),
    .phase_o          (phase_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Advance the predicted recorder by one accepted tick.
  function automatic void step_recorder(input logic pressed);
    case (exp_phase)
      PH_RECORD: begin
        exp_red   = 1'b1;
        exp_green = pressed;
        // A level change opens the next run slot.
        if (pressed != exp_prev_pressed) begin
          exp_prev_pressed = pressed;
          exp_slot         = exp_slot + 1'b1;
        end
        if (exp_runs[exp_slot] != 16'hFFFF) begin
          exp_runs[exp_slot] = exp_runs[exp_slot] + 16'd1;
        end
        // A long enough released run ends the take.
        if (!pressed && exp_runs[exp_slot] >= exp_idle_limit) begin
          exp_red   = 1'b0;
          exp_green = 1'b0;
          exp_phase = PH_PLAY;
          exp_slot  = '0;
        end
      end
      PH_PLAY: begin
        // Empty slots only step the index and flip the lamp polarity.
        if (exp_runs[exp_slot] == 16'd0) begin
          exp_slot     = exp_slot + 1'b1;
          exp_play_lit = ~exp_play_lit;
        end else begin
          exp_red            = 1'b0;
          exp_green          = exp_play_lit;
          exp_runs[exp_slot] = exp_runs[exp_slot] - 16'd1;
        end
      end
      PH_IDLE: begin
        if (pressed) begin
          exp_phase        = PH_RECORD;
          exp_prev_pressed = 1'b1;
          exp_slot         = '0;
          exp_runs[0]      = 16'd1;
        end
      end
      default: ;
    endcase

    // Reaching the slot limit ends a take or a playback.
    if (exp_slot >= exp_slot_limit) begin
      if (exp_phase == PH_RECORD) begin
        exp_phase = PH_PLAY;
        exp_slot  = '0;
      end else if (exp_phase == PH_PLAY) begin
        exp_phase    = PH_IDLE;
        exp_red      = 1'b0;
        exp_green    = 1'b0;
        exp_play_lit = 1'b1;
      end
    end
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 30) begin
      $display("[%0t] tick result mismatch: %s", $time, what);
    end
  endtask

  // Offer one tick, wait for its transfer, then record what it must produce.
  task automatic send_tick(input logic pressed);
    tick_out_t want;
    @(negedge clk_i);
    while (!steady && $urandom_range(0, 99) < 16) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    button_pressed_i <= pressed;
    do @(posedge clk_i); while (!in_ready_o);
    step_recorder(pressed);
    want.red   = exp_red;
    want.green = exp_green;
    want.phase = exp_phase;
    pending_leds.push_back(want);
    ticks_sent++;
  endtask

  // Limits are only changed once every owed result has come back.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_leds.size() != 0) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    if (idx == CFG_IDLE_TICK_LIMIT) begin
      exp_idle_limit = data;
    end else begin
      exp_slot_limit = data[IDX_BITS-1:0];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Tick until the block is back in idle; stray presses during playback
  // must be ignored.
  task automatic drain_playback();
    while (exp_phase != PH_IDLE) begin
      send_tick($urandom_range(0, 9) == 0);
    end
  endtask

  // Out of reset the block plays back an empty memory before going idle.
  task automatic test_power_up_playback();
    drain_playback();
    send_tick(1'b0);
    send_tick(1'b0);
  endtask

  // Reset limits: a short pattern, then single tick runs until the default
  // slot limit ends the take.
  task automatic test_default_limits();
    logic level;
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    repeat (3) send_tick(1'b1);
    level = 1'b1;
    while (exp_phase == PH_RECORD) begin
      level = ~level;
      send_tick(level);
    end
    drain_playback();
  endtask

  // Smallest, largest and zero limits, plus masking of the slot limit.
  task automatic test_limit_extremes();
    logic level;
    write_reg(CFG_IDLE_TICK_LIMIT, 16'd1);
    write_reg(CFG_SLOT_LIMIT, 16'd1);
    send_tick(1'b1);
    send_tick(1'b0);
    drain_playback();

    // The first slot advance hits the limit; that slot keeps its count.
    write_reg(CFG_IDLE_TICK_LIMIT, 16'hFFFF);
    send_tick(1'b1);
    send_tick(1'b0);
    drain_playback();

    // Fill the memory up to slot 63 with single tick runs.
    write_reg(CFG_SLOT_LIMIT, 16'hFFFF);
    send_tick(1'b1);
    level = 1'b1;
    while (exp_phase == PH_RECORD) begin
      level = ~level;
      send_tick(level);
    end
    drain_playback();

    // Zero limits end record and playback at once.
    write_reg(CFG_IDLE_TICK_LIMIT, 16'd0);
    write_reg(CFG_SLOT_LIMIT, 16'd0);
    send_tick(1'b1);
    drain_playback();
    write_reg(CFG_SLOT_LIMIT, 16'hFFC5);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    drain_playback();
  endtask

  // Random takes: mostly clean alternating runs, with some flipped ticks,
  // idle noise and stray presses during playback.
  task automatic test_random_takes();
    int unsigned           start;
    int unsigned           run_left;
    logic                  level;
    logic [15:0]           idle_lim;
    logic [IDX_BITS-1:0]   slot_lim;
    logic [9:0]            junk;
    start = ticks_sent;
    while (ticks_sent - start < 480) begin
      steady = (ticks_sent - start >= 150) && (ticks_sent - start < 300);
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0:       idle_lim = 16'd0;
          1:       idle_lim = 16'hFFFF;
          2:       idle_lim = 16'($urandom_range(11, 400));
          default: idle_lim = 16'($urandom_range(1, 10));
        endcase
        case ($urandom_range(0, 9))
          0:       slot_lim = 6'd0;
          1:       slot_lim = 6'd1;
          2:       slot_lim = 6'd63;
          default: slot_lim = 6'($urandom_range(2, 62));
        endcase
        junk = 10'($urandom_range(0, 1023));
        write_reg(CFG_IDLE_TICK_LIMIT, idle_lim);
        write_reg(CFG_SLOT_LIMIT, {junk, slot_lim});
      end

      repeat ($urandom_range(0, 2)) send_tick(1'b0);
      send_tick(1'b1);
      level    = 1'b1;
      run_left = $urandom_range(0, 4);
      while (exp_phase == PH_RECORD) begin
        if (run_left == 0) begin
          level    = ~level;
          run_left = level ? $urandom_range(1, 5) : $urandom_range(1, 12);
        end
        run_left--;
        if ($urandom_range(0, 99) < 6) begin
          send_tick(1'($urandom_range(0, 1)));
        end else begin
          send_tick(level);
        end
      end
      drain_playback();
    end
    steady = 1'b0;
  endtask

  // The receiver stalls at random, except during the steady stretch.
  always @(negedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(0, 99) >= 16);
  end

  // Compare every output transfer with the oldest owed result.
  always @(posedge clk_i) begin
    tick_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_leds.size() == 0) begin
        report_mismatch("result transfer with no tick outstanding");
      end else begin
        want = pending_leds.pop_front();
        if (red_led_o !== want.red) begin
          report_mismatch($sformatf("red_led got %b want %b", red_led_o, want.red));
        end
        if (green_led_o !== want.green) begin
          report_mismatch($sformatf("green_led got %b want %b", green_led_o, want.green));
        end
        if (phase_o !== want.phase) begin
          report_mismatch($sformatf("phase got %0d want %0d", phase_o, want.phase));
        end
      end
    end
  end

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    button_pressed_i = 1'b0;
    out_ready_i      = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = '0;
    cfg_wdata_i      = '0;
    steady           = 1'b0;
    ticks_sent       = 0;
    errors           = 0;

    // The predictor starts from the reset state of the block.
    exp_phase        = PH_PLAY;
    exp_slot         = '0;
    exp_prev_pressed = 1'b0;
    exp_play_lit     = 1'b1;
    exp_red          = 1'b0;
    exp_green        = 1'b0;
    exp_idle_limit   = IDLE_TICK_LIMIT_RST;
    exp_slot_limit   = SLOT_LIMIT_RST;
    for (int i = 0; i < 64; i++) exp_runs[i] = '0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_power_up_playback();
    test_default_limits();
    test_limit_extremes();
    test_random_takes();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_leds.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog against a stalled handshake.
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ button_pattern_record_playback.f @@
+incdir+sv
sv/bprp_pkg.sv
sv/bprp_run_mem.sv
sv/bprp_tick_core.sv
sv/button_pattern_record_playback.sv
sv/bprp_checker.sv
tb/sv/tb.sv
